// ----- rtl/gaussian_line_smoother_macros.svh -----
// Assertion macros shared by the smoother RTL.
`ifndef GAUSSIAN_LINE_SMOOTHER_MACROS_SVH
`define GAUSSIAN_LINE_SMOOTHER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define GLS_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GLS_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// ----- rtl/gls_pkg.sv -----
// Package with payload types and constants of the line smoother.
package gls_pkg;
	localparam int SAMPLE_W = 16;
	localparam int OUT_W = 24;
	localparam int POS_W = 4;
	localparam logic [POS_W-1:0] POS_MAX = 4'd15;
	localparam int NUM_CFG = 8;
	localparam logic [2:0] CFG_RADIUS = 3'd0;
	localparam logic [2:0] CFG_WEIGHT_0 = 3'd1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       end_of_line;
	} in_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] smoothed;
		logic                    last_of_line;
	} out_word_t;
endpackage

// ----- rtl/gls_divider.sv -----
// Restoring divider computing floor(num / den), one quotient bit per cycle.
module gls_divider #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ----- rtl/gaussian_line_smoother.sv -----
// Top level of the Gaussian line smoother with edge renormalization.
// The block smooths image lines with a symmetric FIR of up to 2*radius+1 taps.
// Input words (sample, end_of_line) enter on in_valid/in_ready; result words
// (smoothed, last_of_line) leave on out_valid/out_ready.  The configuration
// channel cfg_valid/cfg_ready writes radius (index 0) and weight_0..weight_6
// (indexes 1..7) and is always ready; write it only while the block is idle.
// Each output walks the taps one per cycle through a single shared
// multiply-accumulate, then a restoring divider forms the normalized,
// rounded quotient one bit per cycle.  Each output passes through the tap
// walk (ST_MAC), the multiplier drain (ST_MUL), the divider (ST_DIV,
// skipped when the weight sum is zero) and the hand-off states ST_WAIT and
// ST_OUT into the output register; an end-of-line word flushes up to
// radius+1 outputs, each along that path.  The block is not ready while a
// word is being processed, so the rate is set by the MAC walk and divider.
// Reset clears the sample window and the line position and loads the
// default radius and weights.  When the receiver stalls, the finished word
// waits in the output register and the sequencer holds until it is taken.
// The output for position p is issued once sample p+radius has arrived.
module gaussian_line_smoother #(
	parameter int MAX_RADIUS  = 6,
	parameter int SAMPLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gls_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output gls_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	`include "gaussian_line_smoother_macros.svh"

	localparam int DEPTH  = 2 * MAX_RADIUS + 1;
	localparam int IDX_W  = $clog2(DEPTH + 1);
	localparam int PROD_W = SAMPLE_BITS + 17;
	localparam int ACC_W  = PROD_W + 4;
	localparam int DEN_W  = 21;
	localparam int NUM_W  = ACC_W + 10;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MAC  = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_WAIT = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [2:0]  radius_q;
	logic [15:0] weight_q [7];
	logic signed [SAMPLE_BITS-1:0] win_q [DEPTH];
	logic [gls_pkg::POS_W-1:0] pos_q;
	logic [gls_pkg::POS_W-1:0] n_q;
	logic [3:0]  r_q;
	logic [3:0]  j_q;
	logic        last_q;
	logic [4:0]  d_q;
	logic signed [ACC_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic        prod_vld_s1;
	logic        mac_end_q;
	logic        neg_q;
	logic [gls_pkg::OUT_W-1:0] res_q;
	gls_pkg::out_word_t out_q;
	logic        out_valid_q;

	// Tap evaluation for the current distance index.
	logic signed [5:0] dd;
	logic signed [5:0] kk;
	logic [3:0]  ad;
	logic        tap_ok;
	logic [15:0] tap_w;
	logic signed [SAMPLE_BITS-1:0] tap_s;
	logic [3:0]  r_eff;

	assign r_eff = (radius_q > 3'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : {1'b0, radius_q};
	assign dd = $signed({1'b0, d_q}) - $signed({2'b0, r_q});
	assign kk = $signed({2'b0, j_q}) - dd;
	assign ad = dd[5] ? 4'(-dd) : dd[3:0];
	assign tap_ok = !kk[5] && (kk <= $signed({2'b0, n_q})) && (kk < 6'(DEPTH))
		&& (ad <= 4'd6);
	assign tap_w = weight_q[ad[2:0]];
	assign tap_s = win_q[kk[IDX_W-1:0]];

	// Divider operands: q = (mag*512 + den) / (2*den).
	logic [ACC_W-1:0] mag;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic div_start, div_busy, div_done;
	logic [NUM_W-1:0] div_quo;

	assign mag = num_q[ACC_W-1] ? ACC_W'(-num_q) : ACC_W'(num_q);
	assign div_num = NUM_W'({mag, 9'b0}) + NUM_W'(den_q);
	assign div_den = {den_q[DEN_W-2:0], 1'b0};
	assign div_start = (state_q == ST_MUL) && mac_end_q && !prod_vld_s1 && (den_q != '0);

	gls_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .done(div_done), .quo(div_quo)
	);

	// Saturated, signed result.
	logic [gls_pkg::OUT_W-1:0] res;
	always_comb begin
		if (neg_q) begin
			if (div_quo > NUM_W'(24'h800000)) res = 24'h800000;
			else res = 24'(-div_quo[gls_pkg::OUT_W-1:0]);
		end else begin
			if (div_quo > NUM_W'(24'h7FFFFF)) res = 24'h7FFFFF;
			else res = div_quo[gls_pkg::OUT_W-1:0];
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 3'd3;
			weight_q[0] <= 16'd65535;
			weight_q[1] <= 16'd57835;
			weight_q[2] <= 16'd39749;
			weight_q[3] <= 16'd21280;
			weight_q[4] <= 16'd8869;
			weight_q[5] <= 16'd2880;
			weight_q[6] <= 16'd728;
		end else if (cfg_valid) begin
			if (cfg_index == gls_pkg::CFG_RADIUS) radius_q <= cfg_data[2:0];
			else weight_q[cfg_index - gls_pkg::CFG_WEIGHT_0] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= $signed({1'b0, tap_w}) * tap_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < DEPTH; i++) win_q[i] <= '0;
			pos_q <= '0;
			n_q <= '0;
			r_q <= '0;
			j_q <= '0;
			last_q <= 1'b0;
			d_q <= '0;
			num_q <= '0;
			den_q <= '0;
			prod_vld_s1 <= 1'b0;
			mac_end_q <= 1'b0;
			neg_q <= 1'b0;
			res_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			prod_vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						for (int i = DEPTH - 1; i > 0; i--) win_q[i] <= win_q[i-1];
						win_q[0] <= SAMPLE_BITS'(in_data.sample);
						n_q <= pos_q;
						r_q <= r_eff;
						last_q <= in_data.end_of_line;
						if (in_data.end_of_line) begin
							pos_q <= '0;
							j_q <= (pos_q < r_eff) ? pos_q : r_eff;
							state_q <= ST_MAC;
						end else begin
							if (pos_q != gls_pkg::POS_MAX) pos_q <= pos_q + 1'b1;
							j_q <= r_eff;
							if (pos_q >= r_eff) state_q <= ST_MAC;
						end
						d_q <= '0;
						num_q <= '0;
						den_q <= '0;
						mac_end_q <= 1'b0;
					end
				end
				ST_MAC: begin
					if (tap_ok) begin
						den_q <= den_q + DEN_W'(tap_w);
						prod_vld_s1 <= 1'b1;
					end
					if (d_q == 5'({r_q, 1'b0})) begin
						mac_end_q <= 1'b1;
						state_q <= ST_MUL;
					end
					d_q <= d_q + 1'b1;
				end
				ST_MUL: begin
					if (!prod_vld_s1) begin
						neg_q <= num_q[ACC_W-1];
						if (den_q == '0) begin
							res_q <= '0;
							state_q <= ST_WAIT;
						end else state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						res_q <= res;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (!out_valid_q || out_ready) state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_q.smoothed <= res_q;
					out_q.last_of_line <= last_q && (j_q == 4'd0);
					out_valid_q <= 1'b1;
					if (last_q && (j_q != 4'd0)) begin
						j_q <= j_q - 1'b1;
						d_q <= '0;
						num_q <= '0;
						den_q <= '0;
						mac_end_q <= 1'b0;
						state_q <= ST_MAC;
					end else state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (prod_vld_s1) num_q <= num_q + ACC_W'(prod_s1);
		end
	end

	// Output register is only loaded once the previous word has left.
	`GLS_ASSERT_IMP(a_no_overwrite, clk, arst_n, state_q == ST_OUT, !out_valid_q || out_ready)
	// The divider only runs while the sequencer waits for it.
	`GLS_ASSERT_IMP(a_div_owned, clk, arst_n, div_busy, state_q == ST_DIV)
	// An accepted end-of-line word always moves the sequencer to ST_MAC.
	`GLS_ASSERT_NXT(a_accept_leaves, clk, arst_n, in_valid && in_ready && in_data.end_of_line,
		state_q == ST_MAC)
endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the Gaussian line smoother.
module tb;
	localparam int WIN_DEPTH = 13;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	gls_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	gls_pkg::out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	always #1 clk = ~clk;

	gaussian_line_smoother u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow of the block's configuration and line state, advanced once per
	// accepted input word.
	int unsigned cur_radius;
	logic [15:0] tap_weight [0:6];
	logic signed [15:0] line_hist [0:WIN_DEPTH-1];
	int unsigned line_pos;
	gls_pkg::out_word_t pending_pixels [$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit run_done = 1'b0;

	// Renormalized weighted average around the pixel j words behind the newest
	// one, given n words before the newest in this line.
	function automatic logic signed [23:0] smooth_pixel(int j, int n, int r);
		longint num;
		longint den;
		longint mag;
		longint q;
		int k;
		int ad;
		num = 0;
		den = 0;
		for (int d = -r; d <= r; d++) begin
			k = j - d;
			ad = d < 0 ? -d : d;
			if (k >= 0 && k <= n && k < WIN_DEPTH) begin
				num += longint'(tap_weight[ad]) * longint'(line_hist[k]);
				den += longint'(tap_weight[ad]);
			end
		end
		if (den == 0) begin
			return '0;
		end
		mag = num < 0 ? -num : num;
		q = (mag * 512 + den) / (2 * den);
		if (num < 0) begin
			if (q > 8388608) q = 8388608;
			return 24'(-q);
		end
		if (q > 8388607) q = 8388607;
		return 24'(q);
	endfunction

	// Advance the shadow state with one accepted word and queue its pixels.
	task automatic predict_word(gls_pkg::in_word_t w);
		int r;
		int n;
		gls_pkg::out_word_t o;
		r = cur_radius > 6 ? 6 : cur_radius;
		n = line_pos;
		for (int k = WIN_DEPTH - 1; k > 0; k--) line_hist[k] = line_hist[k-1];
		line_hist[0] = w.sample;
		if (!w.end_of_line) begin
			if (n >= r) begin
				o.smoothed = smooth_pixel(r, n, r);
				o.last_of_line = 1'b0;
				pending_pixels.push_back(o);
			end
			line_pos = n + 1 > 15 ? 15 : n + 1;
		end else begin
			for (int j = (n < r ? n : r); j >= 0; j--) begin
				o.smoothed = smooth_pixel(j, n, r);
				o.last_of_line = (j == 0);
				pending_pixels.push_back(o);
			end
			line_pos = 0;
		end
	endtask

	// Send one word after a random gap; prediction happens at acceptance.
	// Valid stays high after acceptance until the next word or an idle wait
	// replaces it in the same time step.
	task automatic send_word(logic signed [15:0] s, logic eol);
		gls_pkg::in_word_t w;
		int gap;
		gap = $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.sample = s;
		w.end_of_line = eol;
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		predict_word(w);
	endtask

	// Wait until every pixel has come, then let the sequencer settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == gls_pkg::CFG_RADIUS) cur_radius = val[2:0];
		else tap_weight[idx - gls_pkg::CFG_WEIGHT_0] = val;
		@(posedge clk);
	endtask

	task automatic send_line(int len, int mode);
		logic signed [15:0] s;
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: s = 16'($urandom);
				1: s = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
				default: s = 16'($urandom_range(0, 255)) - 16'sd128;
			endcase
			send_word(s, i == len - 1);
		end
	endtask

	// Extremes of the sample, a one-word line, lines shorter than the radius
	// and a line long enough to saturate the line position.
	task automatic test_directed();
		send_word(16'sh7fff, 1'b1);
		send_word(-16'sh8000, 1'b0);
		send_word(16'sh7fff, 1'b0);
		send_word(-16'sh8000, 1'b1);
		send_line(20, 1);
	endtask

	// All weights zero, so every pixel is forced to zero; a single nonzero
	// center weight passes the samples through, scaled by 256.
	task automatic test_zero_weights();
		for (int i = 0; i < 7; i++) write_reg(gls_pkg::CFG_WEIGHT_0 + 3'(i), 16'd0);
		write_reg(gls_pkg::CFG_RADIUS, 3'd6);
		send_line(8, 0);
		wait_idle();
		write_reg(gls_pkg::CFG_WEIGHT_0, 16'hffff);
		write_reg(gls_pkg::CFG_RADIUS, 3'd0);
		send_line(5, 0);
		wait_idle();
	endtask

	// Sweeps every radius setting from 0 to 7 with random weights; a radius beyond the maximum is clamped by the block.
	task automatic test_radius_sweep();
		for (int rv = 0; rv < 8; rv++) begin
			write_reg(gls_pkg::CFG_RADIUS, 3'(rv));
			for (int i = 1; i < 7; i++)
				write_reg(gls_pkg::CFG_WEIGHT_0 + 3'(i), 16'($urandom));
			send_line($urandom_range(1, 4), 0);
			send_line($urandom_range(5, 18), 2);
			wait_idle();
		end
	endtask

	task automatic test_random();
		int words;
		int len;
		words = 0;
		while (words < 150) begin
			len = $urandom_range(0, 9) == 0 ? $urandom_range(14, 22) : $urandom_range(1, 10);
			send_line(len, $urandom_range(0, 2));
			words += len;
			if ($urandom_range(0, 9) == 0) begin
				wait_idle();
				write_reg(gls_pkg::CFG_RADIUS, 3'($urandom_range(0, 7)));
				write_reg(3'($urandom_range(1, 7)), 16'($urandom));
			end
		end
	endtask

	// Receiver side: a random stall before each pixel, then check it.
	initial begin
		int gap;
		forever begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: smoothed=%0d last=%0b",
						out_data.smoothed, out_data.last_of_line);
			end else begin
				if (out_data !== pending_pixels[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %0d/%0b actual %0d/%0b",
							pending_pixels[0].smoothed, pending_pixels[0].last_of_line,
							out_data.smoothed, out_data.last_of_line);
				end
				void'(pending_pixels.pop_front());
			end
		end
	end

	// Watchdog on cycles with no accepted word on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT && !run_done) begin
			$display("gaussian_line_smoother test failed");
			$finish;
		end
	end

	initial begin
		cur_radius = 3;
		tap_weight = '{16'd65535, 16'd57835, 16'd39749, 16'd21280, 16'd8869,
			16'd2880, 16'd728};
		foreach (line_hist[k]) line_hist[k] = '0;
		line_pos = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_idle();
		test_zero_weights();
		test_radius_sweep();
		test_random();
		wait_idle();
		run_done = 1'b1;
		if (mismatch_count == 0 && pending_pixels.size() == 0)
			$display("gaussian_line_smoother test passed");
		else
			$display("gaussian_line_smoother test failed");
		$finish;
	end
endmodule
